// ----- hdl/mpfr_pkg.sv -----
// shared types, constants and the crc16 byte update for the position frame receiver
package mpfr_pkg;

   // configuration register indexes
   localparam logic [7:0] CSR_STATION_ADDRESS = 8'd0;
   localparam logic [7:0] CSR_FUNCTION_CODE   = 8'd1;
   localparam logic [7:0] CSR_MIN_PAYLOAD     = 8'd2;
   localparam logic [7:0] CSR_MAX_PAYLOAD     = 8'd3;

   // register reset values
   localparam logic [7:0] STATION_ADDRESS_RST = 8'd1;
   localparam logic [7:0] FUNCTION_CODE_RST   = 8'd3;
   localparam logic [7:0] MIN_PAYLOAD_RST     = 8'd4;
   localparam logic [7:0] MAX_PAYLOAD_RST     = 8'd90;

   // frame layout constants
   localparam logic [7:0]  HARD_MAX_PAYLOAD = 8'd250;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'hA001;
   localparam logic [7:0]  TAG_FIRST        = 8'hAC;
   localparam logic [7:0]  TAG_SECOND       = 8'hDA;
   localparam logic [7:0]  FIELD_BASE       = 8'd6;
   localparam logic [7:0]  MASK_SKIP        = 8'd32;
   localparam logic [7:0]  HEADER_BYTES     = 8'd3;

   // result status codes
   typedef enum logic [2:0] {
      STATUS_CRC_BAD   = 3'd0,
      STATUS_TAG_BAD   = 3'd1,
      STATUS_TOO_SHORT = 3'd2,
      STATUS_NO_FIX    = 3'd3,
      STATUS_POS_VALID = 3'd4
   } status_type;

   // configuration register contents
   typedef struct packed {
      logic [7:0] station_address;
      logic [7:0] function_code;
      logic [7:0] min_payload;
      logic [7:0] max_payload;
   } cfg_type;

   // modbus crc16 over one byte, reflected polynomial
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- hdl/mpfr_csr_regs.sv -----
// configuration registers of the position frame receiver
module mpfr_csr_regs (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_index,
   input  logic [7:0]       csr_data,
   output mpfr_pkg::cfg_type cfg
);
   import mpfr_pkg::*;

   cfg_type cfg_ff;

   // always able to take a write
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write on each completed transfer, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.station_address <= STATION_ADDRESS_RST;
         cfg_ff.function_code   <= FUNCTION_CODE_RST;
         cfg_ff.min_payload     <= MIN_PAYLOAD_RST;
         cfg_ff.max_payload     <= MAX_PAYLOAD_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STATION_ADDRESS: cfg_ff.station_address <= csr_data;
            CSR_FUNCTION_CODE:   cfg_ff.function_code   <= csr_data;
            CSR_MIN_PAYLOAD:     cfg_ff.min_payload     <= csr_data;
            CSR_MAX_PAYLOAD:     cfg_ff.max_payload     <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

// ----- hdl/mpfr_parser.sv -----
// frame parser: per-byte state update, crc, field capture and the result register
module mpfr_parser (
   input  logic                clock,
   input  logic                reset,
   input  mpfr_pkg::cfg_type   cfg,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   output logic                in_take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_frame_status,
   output logic signed [15:0]  rsp_pos_x_cm,
   output logic signed [15:0]  rsp_pos_y_cm
);
   import mpfr_pkg::*;

   typedef enum logic [1:0] {
      PH_ADDRESS  = 2'd0,
      PH_FUNCTION = 2'd1,
      PH_LENGTH   = 2'd2,
      PH_FRAME    = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  byte_pos_ff, byte_pos_in;
   logic [7:0]  pay_len_ff, pay_len_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_end_ff, crc_end_in;
   logic [15:0] last_two_ff, last_two_in;
   logic [2:0]  header_ff, header_in;     // bit0 tag first, bit1 tag second, bit2 mask
   logic [47:0] captured_ff, captured_in; // location flag, x, y

   logic              rsp_valid_ff;
   status_type        status_ff, status_in;
   logic signed [15:0] pos_x_ff, pos_x_in;
   logic signed [15:0] pos_y_ff, pos_y_in;
   logic              emit;

   logic [7:0]  idx;
   logic [7:0]  field_base;
   logic [7:0]  field_off;
   logic [15:0] sent_crc;
   logic [15:0] crc_feed;

   // a byte is taken unless a result is still waiting and stalled
   assign in_take = in_valid && !(rsp_valid_ff && rsp_stall);

   assign idx        = byte_pos_ff - HEADER_BYTES;
   assign field_base = header_ff[2] ? (FIELD_BASE + MASK_SKIP) : FIELD_BASE;
   assign field_off  = idx - field_base;
   assign sent_crc   = {in_byte, last_two_ff[7:0]};

   // next state for the byte under work
   always_comb begin
      phase_in    = phase_ff;
      byte_pos_in = byte_pos_ff;
      pay_len_in  = pay_len_ff;
      crc_in      = crc_ff;
      crc_end_in  = crc_end_ff;
      last_two_in = last_two_ff;
      header_in   = header_ff;
      captured_in = captured_ff;
      emit        = 1'b0;
      status_in   = STATUS_CRC_BAD;
      pos_x_in    = '0;
      pos_y_in    = '0;
      crc_feed    = crc16_feed((phase_ff == PH_ADDRESS) ? CRC_INIT : crc_ff, in_byte);
      case (phase_ff)
         PH_ADDRESS: begin
            if (in_byte == cfg.station_address) begin
               crc_in   = crc_feed;
               phase_in = PH_FUNCTION;
            end
         end
         PH_FUNCTION: begin
            if (in_byte == cfg.function_code) begin
               crc_in   = crc_feed;
               phase_in = PH_LENGTH;
            end else begin
               phase_in = PH_ADDRESS;
            end
         end
         PH_LENGTH: begin
            if (in_byte >= cfg.min_payload && in_byte <= cfg.max_payload &&
                in_byte <= HARD_MAX_PAYLOAD) begin
               crc_in      = crc_feed;
               crc_end_in  = crc_feed;
               pay_len_in  = in_byte;
               byte_pos_in = HEADER_BYTES;
               header_in   = '0;
               captured_in = '0;
               last_two_in = '0;
               phase_in    = PH_FRAME;
            end else begin
               phase_in = PH_ADDRESS;
            end
         end
         default: begin
            // payload bytes feed the crc and the field capture
            if (idx < pay_len_ff) begin
               crc_in     = crc_feed;
               crc_end_in = crc_feed;
               if (idx == 8'd0 && in_byte == TAG_FIRST) header_in[0] = 1'b1;
               if (idx == 8'd1 && in_byte == TAG_SECOND) header_in[1] = 1'b1;
               if (idx == 8'd3 && in_byte[0]) header_in[2] = 1'b1;
               if (idx >= 8'd4 && idx >= field_base && idx < field_base + 8'd6) begin
                  for (int k = 0; k < 6; k++) begin
                     if (field_off == 8'(k)) captured_in[47 - 8*k -: 8] = in_byte;
                  end
               end
            end
            last_two_in = {last_two_ff[7:0], in_byte};

            if ({1'b0, byte_pos_ff} + 9'd1 < {1'b0, pay_len_ff} + 9'd5) begin
               byte_pos_in = byte_pos_ff + 8'd1;
            end else begin
               // frame end: judge with the crc sent low byte first
               phase_in = PH_ADDRESS;
               emit     = 1'b1;
               if (sent_crc != crc_end_ff) begin
                  status_in = STATUS_CRC_BAD;
               end else if (pay_len_ff < 8'd2) begin
                  status_in = STATUS_TOO_SHORT;
               end else if (header_ff[1:0] != 2'b11) begin
                  status_in = STATUS_TAG_BAD;
               end else if (pay_len_ff < 8'd4) begin
                  status_in = STATUS_TOO_SHORT;
               end else if (pay_len_ff < field_base + 8'd2) begin
                  status_in = STATUS_TOO_SHORT;
               end else if (captured_ff[47:32] == 16'd0) begin
                  status_in = STATUS_NO_FIX;
               end else if (pay_len_ff < field_base + 8'd6) begin
                  status_in = STATUS_TOO_SHORT;
               end else begin
                  status_in = STATUS_POS_VALID;
                  pos_x_in  = captured_ff[31:16];
                  pos_y_in  = captured_ff[15:0];
               end
            end
         end
      endcase
   end

   // parse state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ADDRESS;
         byte_pos_ff  <= '0;
         pay_len_ff   <= '0;
         crc_ff       <= CRC_INIT;
         crc_end_ff   <= '0;
         last_two_ff  <= '0;
         header_ff    <= '0;
         captured_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_take) begin
            phase_ff    <= phase_in;
            byte_pos_ff <= byte_pos_in;
            pay_len_ff  <= pay_len_in;
            crc_ff      <= crc_in;
            crc_end_ff  <= crc_end_in;
            last_two_ff <= last_two_in;
            header_ff   <= header_in;
            captured_ff <= captured_in;
         end
         if (in_take && emit) begin
            rsp_valid_ff <= 1'b1;
            status_ff    <= status_in;
            pos_x_ff     <= pos_x_in;
            pos_y_ff     <= pos_y_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_pos_x_cm     = pos_x_ff;
   assign rsp_pos_y_cm     = pos_y_ff;

endmodule

// ----- hdl/modbus_position_frame_receiver.sv -----
// Receives one serial byte per transfer and delivers one position result per
// complete frame: station address, function code, bounded length byte,
// payload and a Modbus CRC16 sent low byte first. A byte may be offered on
// every clock cycle; it is held in an input register and parsed from there,
// and parsing the last CRC byte also loads the result register. The only limit
// on rate is the result register: while a result waits under rsp_stall no byte
// is parsed, the byte in the input register is held and req_stall is raised for
// the next one. Configuration writes are always taken and apply from the next
// parsed byte; make them only while idle.
module modbus_position_frame_receiver (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_frame_status,
   output logic signed [15:0] rsp_pos_x_cm,
   output logic signed [15:0] rsp_pos_y_cm,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [7:0]         csr_data
);
   import mpfr_pkg::*;

   cfg_type    cfg;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_take;

   // configuration registers
   mpfr_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // input register, refilled in the same cycle it is drained
   assign req_stall = in_valid_ff && !in_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (in_take) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // parser and result register
   mpfr_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .in_valid         (in_valid_ff),
      .in_byte          (in_byte_ff),
      .in_take          (in_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_status (rsp_frame_status),
      .rsp_pos_x_cm     (rsp_pos_x_cm),
      .rsp_pos_y_cm     (rsp_pos_y_cm)
   );

`ifndef SYNTHESIS
   // a new result only follows a parsed byte
   a_rsp_from_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(in_valid_ff))
      else $error("result appeared without a parsed byte");

   // coordinates are zero unless the position is valid
   a_zero_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status != STATUS_POS_VALID |->
         rsp_pos_x_cm == 16'sd0 && rsp_pos_y_cm == 16'sd0)
      else $error("coordinates set on a failed frame");

   // input is held back only for a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");
`endif

endmodule

// ----- verif/position_frame_checker.sv -----
// checker for the position frame receiver: predicts results from accepted bytes and compares
module position_frame_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [2:0]         rsp_frame_status,
   input  logic signed [15:0] rsp_pos_x_cm,
   input  logic signed [15:0] rsp_pos_y_cm,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [7:0]         csr_data,
   output int                 failures,
   output int                 outstanding
);
   import mpfr_pkg::*;

   // frame layout as the protocol defines it
   localparam logic [15:0] CRC_SEED           = 16'hFFFF;
   localparam logic [15:0] CRC_REFLECTED_POLY = 16'hA001;
   localparam logic [7:0]  SYNC_TAG_0         = 8'hAC;
   localparam logic [7:0]  SYNC_TAG_1         = 8'hDA;
   localparam int LENGTH_CEILING = 250;
   localparam int FIELDS_OFFSET  = 6;
   localparam int MASK_EXTRA     = 32;
   localparam int FIELDS_BYTES   = 6;
   localparam int FLAG_BYTES     = 2;
   localparam int TAG_BYTES      = 2;
   localparam int MASK_END       = 4;
   localparam int HEADER_LEN     = 3;
   localparam int TRAILER_BYTES  = 2;

   typedef enum logic [1:0] {
      SEEK_ADDRESS,
      SEEK_FUNCTION,
      SEEK_LENGTH,
      IN_BODY
   } rx_phase_type;

   typedef struct packed {
      status_type         status;
      logic signed [15:0] x_cm;
      logic signed [15:0] y_cm;
   } position_report_type;

   position_report_type pending_reports[$];
   cfg_type          cfg;
   rx_phase_type     rx_phase;
   logic [7:0]       body_pos;
   logic [7:0]       body_len;
   logic [15:0]      crc_run;
   logic [15:0]      crc_body;
   logic [15:0]      crc_tail;
   logic             tag_first_seen;
   logic             tag_second_seen;
   logic             mask_seen;
   logic [47:0]      pos_fields;
   int               mismatch_total = 0;

   // modbus crc16, one byte, lsb first
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] octet);
      logic [15:0] r;
      r = acc ^ {8'h00, octet};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_REFLECTED_POLY) : (r >> 1);
      return r;
   endfunction

   // offset of the location flag within the payload
   function automatic int fields_start();
      return FIELDS_OFFSET + (mask_seen ? MASK_EXTRA : 0);
   endfunction

   // verdict on a finished frame, crc first
   function automatic status_type judge_frame();
      int base;
      base = fields_start();
      if ({crc_tail[7:0], crc_tail[15:8]} != crc_body) return STATUS_CRC_BAD;
      if (int'(body_len) < TAG_BYTES) return STATUS_TOO_SHORT;
      if (!(tag_first_seen && tag_second_seen)) return STATUS_TAG_BAD;
      if (int'(body_len) < MASK_END) return STATUS_TOO_SHORT;
      if (int'(body_len) < base + FLAG_BYTES) return STATUS_TOO_SHORT;
      if (pos_fields[47:32] == 16'h0000) return STATUS_NO_FIX;
      if (int'(body_len) < base + FIELDS_BYTES) return STATUS_TOO_SHORT;
      return STATUS_POS_VALID;
   endfunction

   // advance the parser by one received byte
   task automatic decode_rx_byte(input logic [7:0] octet);
      int idx;
      int base;
      position_report_type rep;
      case (rx_phase)
         SEEK_ADDRESS: begin
            if (octet == cfg.station_address) begin
               crc_run  = crc16_step(CRC_SEED, octet);
               rx_phase = SEEK_FUNCTION;
            end
         end
         SEEK_FUNCTION: begin
            if (octet == cfg.function_code) begin
               crc_run  = crc16_step(crc_run, octet);
               rx_phase = SEEK_LENGTH;
            end else begin
               rx_phase = SEEK_ADDRESS;
            end
         end
         SEEK_LENGTH: begin
            if (octet >= cfg.min_payload && octet <= cfg.max_payload &&
                int'(octet) <= LENGTH_CEILING) begin
               crc_run         = crc16_step(crc_run, octet);
               crc_body        = crc_run;
               body_len        = octet;
               body_pos        = 8'(HEADER_LEN);
               tag_first_seen  = 1'b0;
               tag_second_seen = 1'b0;
               mask_seen       = 1'b0;
               pos_fields      = '0;
               crc_tail        = '0;
               rx_phase        = IN_BODY;
            end else begin
               rx_phase = SEEK_ADDRESS;
            end
         end
         default: begin
            idx = int'(body_pos) - HEADER_LEN;
            // payload bytes feed the crc and the captured fields
            if (idx < int'(body_len)) begin
               crc_run  = crc16_step(crc_run, octet);
               crc_body = crc_run;
               base     = fields_start();
               if (idx == 0 && octet == SYNC_TAG_0) tag_first_seen = 1'b1;
               if (idx == 1 && octet == SYNC_TAG_1) tag_second_seen = 1'b1;
               if (idx == 3 && octet[0]) mask_seen = 1'b1;
               if (idx >= MASK_END && idx >= base && idx < base + FIELDS_BYTES) begin
                  pos_fields[8 * (FIELDS_BYTES - 1 - (idx - base)) +: 8] = octet;
               end
            end
            crc_tail = {crc_tail[7:0], octet};
            if (int'(body_pos) + 1 < int'(body_len) + HEADER_LEN + TRAILER_BYTES) begin
               body_pos = body_pos + 8'd1;
            end else begin
               rep.status = judge_frame();
               rep.x_cm   = (rep.status == STATUS_POS_VALID) ? pos_fields[31:16] : '0;
               rep.y_cm   = (rep.status == STATUS_POS_VALID) ? pos_fields[15:0] : '0;
               pending_reports.push_back(rep);
               rx_phase = SEEK_ADDRESS;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : monitor
      position_report_type want;
      if (reset) begin
         cfg = '{STATION_ADDRESS_RST, FUNCTION_CODE_RST, MIN_PAYLOAD_RST, MAX_PAYLOAD_RST};
         rx_phase        = SEEK_ADDRESS;
         body_pos        = '0;
         body_len        = '0;
         crc_run         = CRC_SEED;
         crc_body        = '0;
         crc_tail        = '0;
         tag_first_seen  = 1'b0;
         tag_second_seen = 1'b0;
         mask_seen       = 1'b0;
         pos_fields      = '0;
         pending_reports.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STATION_ADDRESS: cfg.station_address = csr_data;
               CSR_FUNCTION_CODE:   cfg.function_code = csr_data;
               CSR_MIN_PAYLOAD:     cfg.min_payload = csr_data;
               CSR_MAX_PAYLOAD:     cfg.max_payload = csr_data;
               default: ;
            endcase
         end
         // accepted input byte
         if (req_valid && !req_stall) decode_rx_byte(req_rx_byte);
         // accepted result against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               $error("unexpected result transfer: frame_status %0d", rsp_frame_status);
               mismatch_total++;
            end else begin
               want = pending_reports.pop_front();
               if (rsp_frame_status !== want.status) begin
                  $error("frame_status: expected %0d, actual %0d", want.status, rsp_frame_status);
                  mismatch_total++;
               end
               if (rsp_pos_x_cm !== want.x_cm) begin
                  $error("pos_x_cm: expected %0d, actual %0d", $signed(want.x_cm), rsp_pos_x_cm);
                  mismatch_total++;
               end
               if (rsp_pos_y_cm !== want.y_cm) begin
                  $error("pos_y_cm: expected %0d, actual %0d", $signed(want.y_cm), rsp_pos_y_cm);
                  mismatch_total++;
               end
            end
         end
      end
      failures    <= mismatch_total;
      outstanding <= pending_reports.size();
   end

endmodule

// ----- verif/tb.sv -----
// testbench top for the position frame receiver: stimulus, idling and the verdict
module tb;
   import mpfr_pkg::*;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RUN_LIMIT       = 400000;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_BYTES     = 150;
   localparam int PHASE_FRAMES    = 4;
   localparam int POS_BYTES       = 6;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic [2:0]         rsp_frame_status;
   logic signed [15:0] rsp_pos_x_cm;
   logic signed [15:0] rsp_pos_y_cm;
   logic               csr_valid   = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_index   = 8'h00;
   logic [7:0]         csr_data    = 8'h00;
   int                 failures;
   int                 outstanding;

   cfg_type link_cfg;
   int      send_idle_pct  = 0;
   int      stall_pct      = 0;
   bit      hold_off_armed = 1'b0;
   int      bytes_sent     = 0;
   int      frames_sent    = 0;

   modbus_position_frame_receiver dut (.*);
   position_frame_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard limit on the run
   initial begin
      #RUN_LIMIT;
      $display("status: fail");
      $finish;
   end

   // result side: random stall, with one long hold-off on request
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // one byte transfer, with random gaps in front
   task automatic put_byte(input logic [7:0] octet);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= octet;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // whole frame; fields holds flag, x and y big-endian
   task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                             input logic [7:0] len, input bit tag_ok, input bit mask_on,
                             input logic [47:0] fields, input bit crc_ok);
      logic [15:0] crc;
      logic [7:0]  octet;
      int          base;
      int          break_at;
      base     = FIELD_BASE + (mask_on ? MASK_SKIP : 0);
      break_at = $urandom_range(1);
      crc = crc16_feed(CRC_INIT, addr);
      put_byte(addr);
      crc = crc16_feed(crc, func);
      put_byte(func);
      crc = crc16_feed(crc, len);
      put_byte(len);
      for (int i = 0; i < int'(len); i++) begin
         octet = 8'($urandom_range(255));
         if (i == 0) octet = TAG_FIRST;
         else if (i == 1) octet = TAG_SECOND;
         else if (i == 3) octet[0] = mask_on;
         else if (i >= base && i < base + POS_BYTES) begin
            octet = fields[8 * (POS_BYTES - 1 - (i - base)) +: 8];
         end
         if (!tag_ok && i == break_at) octet = octet ^ 8'($urandom_range(1, 255));
         crc = crc16_feed(crc, octet);
         put_byte(octet);
      end
      // crc goes low byte first
      if (!crc_ok) crc = crc ^ 16'($urandom_range(1, 65535));
      put_byte(crc[7:0]);
      put_byte(crc[15:8]);
      frames_sent++;
   endtask

   // write all four registers while the block is idle
   task automatic apply_config(input logic [7:0] station, input logic [7:0] func,
                               input logic [7:0] lo, input logic [7:0] hi);
      logic [7:0] regs[4];
      logic [7:0] values[4];
      regs   = '{CSR_STATION_ADDRESS, CSR_FUNCTION_CODE, CSR_MIN_PAYLOAD, CSR_MAX_PAYLOAD};
      values = '{station, func, lo, hi};
      for (int r = 0; r < 4; r++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[r];
         csr_data  <= values[r];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      link_cfg = '{station, func, lo, hi};
   endtask

   // stop sending and wait for every predicted result
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 63; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 63; end
         default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
   endtask

   // mostly well-formed frames with random content, some noise and broken headers
   task automatic random_traffic(input int byte_goal, input int frame_goal);
      int          first_byte;
      int          first_frame;
      int          pick;
      int          len;
      int          base;
      bit          mask_on;
      logic [15:0] flag;
      first_byte  = bytes_sent;
      first_frame = frames_sent;
      while (bytes_sent - first_byte < byte_goal || frames_sent - first_frame < frame_goal) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            put_byte(8'($urandom_range(255)));
         end else if (pick < 10) begin
            put_byte(link_cfg.station_address);
            put_byte(link_cfg.function_code ^ 8'($urandom_range(1, 255)));
         end else if (pick < 15) begin
            if (link_cfg.min_payload > 0 && $urandom_range(1) == 1) begin
               len = $urandom_range(int'(link_cfg.min_payload) - 1);
            end else begin
               len = $urandom_range(255, int'(link_cfg.max_payload) + 1);
            end
            put_byte(link_cfg.station_address);
            put_byte(link_cfg.function_code);
            put_byte(8'(len));
         end else begin
            mask_on = ($urandom_range(99) < 30);
            base    = FIELD_BASE + (mask_on ? MASK_SKIP : 0);
            if ($urandom_range(99) < 2) begin
               len = $urandom_range(link_cfg.max_payload, link_cfg.min_payload);
            end else if ($urandom_range(99) < 70) begin
               len = base + POS_BYTES + $urandom_range(6);
            end else begin
               len = $urandom_range(int'(link_cfg.min_payload) + 50, link_cfg.min_payload);
            end
            if (len > int'(link_cfg.max_payload)) len = link_cfg.max_payload;
            if (len < int'(link_cfg.min_payload)) len = link_cfg.min_payload;
            flag = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
            send_frame(link_cfg.station_address, link_cfg.function_code, 8'(len),
                       $urandom_range(99) < 90, mask_on,
                       {flag, 16'($urandom_range(65535)), 16'($urandom_range(65535))},
                       $urandom_range(99) < 90);
         end
      end
   endtask

   initial begin : stimulus
      logic [7:0] lo;
      logic [7:0] hi;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      link_cfg = '{STATION_ADDRESS_RST, FUNCTION_CODE_RST, MIN_PAYLOAD_RST, MAX_PAYLOAD_RST};
      @(posedge clock);

      // reset settings: header rejects, each status, extreme coordinates
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(STATION_ADDRESS_RST);
      put_byte(FUNCTION_CODE_RST ^ 8'h01);
      put_byte(STATION_ADDRESS_RST);
      put_byte(FUNCTION_CODE_RST);
      put_byte(MIN_PAYLOAD_RST - 8'd1);
      send_frame(STATION_ADDRESS_RST, FUNCTION_CODE_RST, 8'd4, 1'b1, 1'b0, 48'h0, 1'b0);
      send_frame(STATION_ADDRESS_RST, FUNCTION_CODE_RST, 8'd4, 1'b0, 1'b0, 48'h0, 1'b1);
      send_frame(STATION_ADDRESS_RST, FUNCTION_CODE_RST, 8'd4, 1'b1, 1'b0, 48'h0, 1'b1);
      send_frame(STATION_ADDRESS_RST, FUNCTION_CODE_RST, 8'd8, 1'b1, 1'b0,
                 48'h0000_1234_5678, 1'b1);
      send_frame(STATION_ADDRESS_RST, FUNCTION_CODE_RST, 8'd8, 1'b1, 1'b0,
                 48'h0100_0000_0000, 1'b1);
      send_frame(STATION_ADDRESS_RST, FUNCTION_CODE_RST, 8'd12, 1'b1, 1'b0,
                 48'h0001_8000_7FFF, 1'b1);
      send_frame(STATION_ADDRESS_RST, FUNCTION_CODE_RST, 8'd44, 1'b1, 1'b1,
                 48'hFFFF_7FFF_8000, 1'b1);
      put_byte(STATION_ADDRESS_RST);
      put_byte(FUNCTION_CODE_RST);
      put_byte(MAX_PAYLOAD_RST + 8'd1);
      drain();

      // widest bounds: tiny payloads, the hard length ceiling, the longest frame
      apply_config(8'h00, 8'h00, 8'd0, HARD_MAX_PAYLOAD);
      send_frame(8'h00, 8'h00, 8'd0, 1'b1, 1'b0, 48'h0, 1'b1);
      send_frame(8'h00, 8'h00, 8'd0, 1'b1, 1'b0, 48'h0, 1'b0);
      send_frame(8'h00, 8'h00, 8'd1, 1'b1, 1'b0, 48'h0, 1'b1);
      send_frame(8'h00, 8'h00, 8'd2, 1'b0, 1'b0, 48'h0, 1'b1);
      send_frame(8'h00, 8'h00, 8'd3, 1'b1, 1'b0, 48'h0, 1'b1);
      put_byte(8'h00);
      put_byte(8'h00);
      put_byte(HARD_MAX_PAYLOAD + 8'd1);
      send_frame(8'h00, 8'h00, HARD_MAX_PAYLOAD, 1'b1, 1'b1, 48'h8000_FFFF_0001, 1'b1);
      drain();

      // lower bound above upper bound: nothing gets past the length byte
      apply_config(8'hFF, 8'hFF, HARD_MAX_PAYLOAD, 8'd0);
      send_frame(8'hFF, 8'hFF, 8'd0, 1'b1, 1'b0, 48'h0, 1'b1);
      send_frame(8'hFF, 8'hFF, 8'd7, 1'b1, 1'b0, 48'h0001_0002_0003, 1'b1);
      put_byte(8'hFF);
      put_byte(8'hFF);
      put_byte(HARD_MAX_PAYLOAD);
      drain();

      // random phases over settings and idling patterns
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         lo = 8'($urandom_range(8));
         hi = 8'($urandom_range(100, 44));
         if (ph == 3) begin
            lo = 8'($urandom_range(50, 12));
            hi = lo;
         end
         if (ph == 6) begin
            lo = 8'd0;
            hi = HARD_MAX_PAYLOAD;
         end
         apply_config(8'($urandom_range(255)), 8'($urandom_range(255)), lo, hi);
         set_idling(ph % 4);
         // long receiver hold-off while bytes keep coming
         if (ph == 4) hold_off_armed = 1'b1;
         random_traffic(PHASE_BYTES, PHASE_FRAMES);
         drain();
      end

      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/mpfr_pkg.sv
hdl/mpfr_csr_regs.sv
hdl/mpfr_parser.sv
hdl/modbus_position_frame_receiver.sv
verif/position_frame_checker.sv
verif/tb.sv
